// ===== rtl/tdf_pkg.sv =====
// Package for the trial division factorizer: beat payload types and
// fixed constants. Depends on nothing; the divider, the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

  // Fixed widths of the channel fields.
  localparam int FIELD_W = 64;
  localparam int EXP_W   = 6;

  // Arithmetic constants of the algorithm.
  localparam logic [FIELD_W-1:0] PRIME_TWO = 64'd2;
  localparam int FIRST_ODD = 3;
  localparam int DSR_STEP  = 2;

  // Payload of one input beat.
  typedef struct packed {
    logic [FIELD_W-1:0] number;
  } num_beat_t;

  // Payload of one result beat.
  typedef struct packed {
    logic [FIELD_W-1:0] prime_factor;
    logic [EXP_W-1:0]   exponent;
    logic               last;
  } fact_beat_t;

endpackage

`default_nettype wire

// ===== rtl/tdf_stream_if.sv =====
// Valid/ready stream interface used for both channels of the factorizer.
// The payload type is a parameter; the beat types come from tdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdf_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/tdf_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Used by trial_division_factorizer; imports tdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdf_divider
  import tdf_pkg::*;
#(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient,
  output logic [DW-1:0]      remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    diff    = trial - {1'b0, div_r};
    fits    = ~diff[DW];
    rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], fits};
  end

  // Control: count the steps and flag the cycle after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: the dividend shifts out at the top while the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== rtl/trial_division_factorizer.sv =====
// Top level of the trial division factorizer: sequencer, residue and output register.
// Depends on tdf_pkg, tdf_stream_if and tdf_divider.
//
//   Channel  Direction  Payload                          Meaning
//   in_if    sink       number                           value to factor
//   out_if   source     prime_factor, exponent, last     one prime and its power
//
// One number is factored at a time; a new number is taken only when the sequencer is idle.
// Factors of two are stripped one trailing zero bit at a time.
// Each trial division runs in the bit-serial divider, and a large prime can need up to
// about 2^(NUMBER_WIDTH/2 - 1) trial divisions.
// Reset is synchronous and clears the sequencer, its working values and the output valid flag.
// A result beat waits in the output register; the sequencer stalls only when it has a
// new result and that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_factorizer
  import tdf_pkg::*;
#(
  parameter int NUMBER_WIDTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tdf_stream_if.sink   in_if,
  tdf_stream_if.source out_if
);

  localparam int NW = NUMBER_WIDTH;
  localparam int DW = (NW + 1) / 2 + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_STRIP  = 4'd1;
  localparam logic [3:0] S_BSTART = 4'd2;
  localparam logic [3:0] S_BWAIT  = 4'd3;
  localparam logic [3:0] S_BDEC   = 4'd4;
  localparam logic [3:0] S_PSTART = 4'd5;
  localparam logic [3:0] S_PWAIT  = 4'd6;
  localparam logic [3:0] S_PDEC   = 4'd7;

  logic [3:0]       state_r, state_nxt;
  logic [NW-1:0]    res_r, res_nxt;
  logic [DW-1:0]    dsr_r, dsr_nxt;
  logic [EXP_W-1:0] pow_r, pow_nxt;
  logic             out_v_r;
  fact_beat_t       out_data_r;

  logic             div_start;
  logic             div_done;
  logic [NW-1:0]    div_quo;
  logic [DW-1:0]    div_rem;
  logic             bound_hit;
  logic             rem_zero;
  logic             out_free;
  logic             emit;
  fact_beat_t       emit_beat;
  logic [NW-1:0]    in_num;

  tdf_divider #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (res_r),
    .divisor   (dsr_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Divisor beyond residue / divisor means no divisor is left below the square root.
  assign in_num    = in_if.payload.number[NW-1:0];
  assign div_start = (state_r == S_BSTART) || (state_r == S_PSTART);
  assign bound_hit = {{(NW-DW){1'b0}}, dsr_r} > div_quo;
  assign rem_zero  = (div_rem == '0);
  assign out_free  = ~out_v_r | out_if.ready;

  // Sequencer: strip twos, then try odd divisors and divide out their full power.
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    dsr_nxt   = dsr_r;
    pow_nxt   = pow_r;
    emit      = 1'b0;
    emit_beat = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          res_nxt = in_num;
          pow_nxt = '0;
          if (in_num > NW'(1)) begin
            state_nxt = S_STRIP;
          end
        end
      end
      S_STRIP: begin
        if (!res_r[0]) begin
          res_nxt = res_r >> 1;
          pow_nxt = pow_r + EXP_W'(1);
        end else if (pow_r == '0 || out_free) begin
          emit                   = (pow_r != '0);
          emit_beat.prime_factor = PRIME_TWO;
          emit_beat.exponent     = pow_r;
          emit_beat.last         = (res_r == NW'(1));
          dsr_nxt                = DW'(FIRST_ODD);
          state_nxt              = (res_r == NW'(1)) ? S_IDLE : S_BSTART;
        end
      end
      S_BSTART: begin
        pow_nxt   = '0;
        state_nxt = S_BWAIT;
      end
      S_BWAIT: begin
        if (div_done) begin
          state_nxt = S_BDEC;
        end
      end
      S_BDEC: begin
        if (bound_hit) begin
          // What is left is itself prime.
          if (out_free) begin
            emit                   = 1'b1;
            emit_beat.prime_factor = FIELD_W'(res_r);
            emit_beat.exponent     = EXP_W'(1);
            emit_beat.last         = 1'b1;
            state_nxt              = S_IDLE;
          end
        end else if (rem_zero) begin
          res_nxt   = div_quo;
          pow_nxt   = EXP_W'(1);
          state_nxt = S_PSTART;
        end else begin
          dsr_nxt   = dsr_r + DW'(DSR_STEP);
          state_nxt = S_BSTART;
        end
      end
      S_PSTART: begin
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_done) begin
          state_nxt = S_PDEC;
        end
      end
      S_PDEC: begin
        if (rem_zero) begin
          res_nxt   = div_quo;
          pow_nxt   = pow_r + EXP_W'(1);
          state_nxt = S_PSTART;
        end else if (out_free) begin
          emit                   = 1'b1;
          emit_beat.prime_factor = FIELD_W'(dsr_r);
          emit_beat.exponent     = pow_r;
          emit_beat.last         = (res_r == NW'(1));
          dsr_nxt                = dsr_r + DW'(DSR_STEP);
          state_nxt              = (res_r == NW'(1)) ? S_IDLE : S_BSTART;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working values of the current number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
      dsr_r <= '0;
      pow_r <= '0;
    end else begin
      res_r <= res_nxt;
      dsr_r <= dsr_nxt;
      pow_r <= pow_nxt;
    end
  end

  // Output register: holds one result beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_beat;
    end
  end

  assign in_if.ready    = (state_r == S_IDLE);
  assign out_if.valid   = out_v_r;
  assign out_if.payload = out_data_r;

endmodule

`default_nettype wire

// ===== verif/tb_trial_division_factorizer.sv =====
// Self-checking testbench for trial_division_factorizer: directed and random numbers,
// factor beats checked against a behavioral factorization. Depends on tdf_pkg,
// tdf_stream_if and the factorizer RTL.
`timescale 1ns / 1ps

module tb_trial_division_factorizer;
  import tdf_pkg::*;

  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          MAX_FACTORS = 15;
  localparam int          QUIET_LIMIT = 100000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          IDLE_PCT    = 24;

  logic clk;
  logic rst_n;
  bit   throttle_on;
  int   mismatch_count;
  int   quiet_cycles;

  // Factor beats still owed by the block, oldest first.
  fact_beat_t pending_factors[$];

  tdf_stream_if #(.payload_t(num_beat_t))  number_bus();
  tdf_stream_if #(.payload_t(fact_beat_t)) factor_bus();

  trial_division_factorizer u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (number_bus),
    .out_if(factor_bus)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Compute the prime factorization of n and queue one beat per distinct prime.
  function automatic void factorize_number(input logic [63:0] n);
    fact_beat_t  found[MAX_FACTORS];
    fact_beat_t  beat;
    logic [63:0] rem;
    logic [63:0] divisor;
    int          power;
    int          cnt;
    rem = n;
    cnt = 0;
    if (rem <= 64'd1) return;
    // Twos come off first.
    power = 0;
    while (!rem[0]) begin
      rem = rem >> 1;
      power++;
    end
    if (power != 0) begin
      found[cnt] = '{prime_factor: PRIME_TWO, exponent: power[EXP_W-1:0], last: 1'b0};
      cnt++;
    end
    // Odd divisors up to the square root of what is left.
    divisor = 64'd3;
    while (divisor <= rem / divisor) begin
      power = 0;
      while (rem % divisor == 64'd0) begin
        rem = rem / divisor;
        power++;
      end
      if (power != 0) begin
        found[cnt] = '{prime_factor: divisor, exponent: power[EXP_W-1:0], last: 1'b0};
        cnt++;
      end
      divisor = divisor + 64'd2;
    end
    if (rem > 64'd1) begin
      found[cnt] = '{prime_factor: rem, exponent: 6'd1, last: 1'b0};
      cnt++;
    end
    for (int i = 0; i < cnt; i++) begin
      beat = found[i];
      beat.last = (i == cnt - 1);
      pending_factors.push_back(beat);
    end
  endfunction

  // Product of small factors and, half the time, one mid-sized cofactor, shifted toward the top bits.
  // The largest prime stays small enough that trial division finishes quickly.
  function automatic logic [63:0] smooth_number();
    logic [63:0] x;
    logic [63:0] f;
    int          nf;
    int          lz;
    x  = 64'd1;
    nf = $urandom_range(1, 12);
    for (int k = 0; k < nf; k++) begin
      f = 64'($urandom_range(2, 97));
      if (x <= ALL_ONES / f) x = x * f;
    end
    if ($urandom_range(1) == 1) begin
      f = 64'($urandom_range(2, 16383));
      if (x <= ALL_ONES / f) x = x * f;
    end
    lz = 0;
    while (lz < 63 && !x[63 - lz]) lz++;
    if ($urandom_range(1) == 1) x = x << lz;
    else x = x << $urandom_range(0, lz);
    return x;
  endfunction

  // Send one number and queue its factors once the beat is taken.
  task automatic send_number(input logic [63:0] n);
    while (throttle_on && $urandom_range(99) < IDLE_PCT) begin
      number_bus.valid <= 1'b0;
      @(posedge clk);
    end
    number_bus.valid   <= 1'b1;
    number_bus.payload <= '{number: n};
    do @(posedge clk); while (!number_bus.ready);
    factorize_number(n);
  endtask

  // Result side stalls at random while throttling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      factor_bus.ready <= 1'b0;
    end else begin
      factor_bus.ready <= throttle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  // Compare every accepted factor beat with the oldest expectation.
  always @(posedge clk) begin
    fact_beat_t want;
    fact_beat_t got;
    if (rst_n && factor_bus.valid && factor_bus.ready) begin
      got = factor_bus.payload;
      if (pending_factors.size() == 0) begin
        $error("unexpected factor beat: prime_factor %0d exponent %0d last %0d",
               got.prime_factor, got.exponent, got.last);
        mismatch_count++;
      end else begin
        want = pending_factors.pop_front();
        if (got.prime_factor !== want.prime_factor) begin
          $error("prime_factor: expected %0d, got %0d", want.prime_factor, got.prime_factor);
          mismatch_count++;
        end
        if (got.exponent !== want.exponent) begin
          $error("exponent: expected %0d, got %0d", want.exponent, got.exponent);
          mismatch_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (number_bus.valid && number_bus.ready) ||
        (factor_bus.valid && factor_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("trial_division_factorizer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Zero and one give nothing; the smallest primes and composites.
  task automatic test_trivial_numbers();
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd2);
    send_number(64'd3);
    send_number(64'd4);
    send_number(64'd6);
    send_number(64'd12);
    send_number(64'd0);
  endtask

  // Largest power of two, top bits set, and a square where the divisor meets the root.
  task automatic test_field_extremes();
    send_number(64'h8000_0000_0000_0000);
    send_number(64'hC000_0000_0000_0000);
    send_number(64'd12157665459056928801);   // three to the fortieth
    send_number(64'd614889782588491410);     // product of the first fifteen primes
    send_number(64'd9);
    send_number(64'd9409);                   // 97 squared
    send_number(64'd65521);                  // largest prime below 2^16
    send_number((64'd1 << 48) * 64'd65521);
    send_number(64'h0000_FFFF_FFFF_FFFF * 64'd97);   // 2^48 - 1 already holds one 97
    send_number(64'd1);
  endtask

  // Random smooth numbers and raw 16-bit values with idling on both sides.
  task automatic test_random_throttled(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       send_number(64'($urandom_range(0, 1)));
        1, 2:    send_number(64'($urandom_range(0, 65535)));
        default: send_number(smooth_number());
      endcase
    end
  endtask

  // Back-to-back beats with no idling anywhere.
  task automatic test_random_burst(input int count);
    throttle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) send_number(64'($urandom_range(0, 65535)));
      else send_number(smooth_number());
    end
    throttle_on = 1'b1;
  endtask

  initial begin
    throttle_on        = 1'b1;
    rst_n              = 1'b0;
    number_bus.valid   = 1'b0;
    number_bus.payload = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_trivial_numbers();
    test_field_extremes();
    test_random_throttled(70);
    test_random_burst(30);
    number_bus.valid <= 1'b0;

    while (pending_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("trial_division_factorizer regression: pass");
    end else begin
      $display("trial_division_factorizer regression: fail");
    end
    $finish;
  end

endmodule
